// ----- hdl/wql_pkg.sv -----
// Shared types, codes and constants for the windowed quota limiter.
package wql_pkg;

  localparam int unsigned UNIT_W  = 32;
  localparam int unsigned TOTAL_W = 64;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [UNIT_W-1:0] MAX_UNITS = {UNIT_W{1'b1}};
  localparam logic [UNIT_W-1:0] ONE_UNIT  = {{(UNIT_W-1){1'b0}}, 1'b1};

  typedef enum logic {
    REQ_CHARGE = 1'b0,
    REQ_CLOSE  = 1'b1
  } req_t;

  typedef enum logic [1:0] {
    VERDICT_OK       = 2'd0,
    VERDICT_THROTTLE = 2'd1,
    VERDICT_KILL     = 2'd2
  } verdict_t;

  localparam logic [CFG_IDX_W-1:0] CFG_CEILING      = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIKE_LIMIT = 1'b1;

  typedef struct packed {
    logic [UNIT_W-1:0]  used;
    logic [UNIT_W-1:0]  peak;
    logic [TOTAL_W-1:0] throttled;
    logic [UNIT_W-1:0]  offences;
    logic [UNIT_W-1:0]  streak;
    logic               hit;
    logic               killed;
  } acct_t;

  typedef struct packed {
    logic       granted;
    verdict_t   verdict;
  } decision_t;

endpackage

// ----- hdl/windowed_quota_limiter.sv -----
// Top level of the windowed quota limiter: input register, accounting state, result register.
// An accepted item passes through the input register, then the result register, to its result.
// Throughput: one item per cycle while results are taken; the combinational path holds the
// ceiling add and compare and the 64-bit throttled total add in the accounting step.
// A stalled consumer holds the result register; the input register takes one more item, then
// the input stalls until the result is taken.
// Synchronous active-low reset clears all accounting state, sets ceiling to 0 (unlimited)
// and the strike limit to 1, and empties both registers.
module windowed_quota_limiter (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [wql_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wql_pkg::UNIT_W-1:0]  cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_req_type,
  input  logic [wql_pkg::UNIT_W-1:0]  in_units,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_granted,
  output logic [1:0]                  out_verdict,
  output logic [wql_pkg::UNIT_W-1:0]  out_used_now,
  output logic [wql_pkg::UNIT_W-1:0]  out_peak_now,
  output logic [wql_pkg::TOTAL_W-1:0] out_throttled_total,
  output logic [wql_pkg::UNIT_W-1:0]  out_offence_count,
  output logic                        out_is_killed
);
  import wql_pkg::*;

  logic [UNIT_W-1:0] ceiling_r;
  logic [UNIT_W-1:0] strike_limit_r;

  logic              stg_vld_r;
  req_t              stg_req_r;
  logic [UNIT_W-1:0] stg_units_r;

  acct_t             acct_r;
  acct_t             acct_nxt;
  decision_t         dec;

  logic              out_vld_r;
  decision_t         out_dec_r;
  acct_t             out_acct_r;

  logic              adv;

  // The held item moves on when the result register is empty or being emptied.
  assign adv      = stg_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !stg_vld_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ceiling_r      <= '0;
      strike_limit_r <= ONE_UNIT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CEILING:      ceiling_r      <= cfg_data;
        CFG_STRIKE_LIMIT: strike_limit_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
    end else if (in_ready) begin
      stg_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stg_req_r   <= req_t'(in_req_type);
      stg_units_r <= in_units;
    end
  end

  wql_step u_step (
    .acct         (acct_r),
    .ceiling      (ceiling_r),
    .strike_limit (strike_limit_r),
    .req_type     (stg_req_r),
    .units        (stg_units_r),
    .acct_nxt     (acct_nxt),
    .dec          (dec)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acct_r    <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (adv) begin
        acct_r <= acct_nxt;
      end
      out_vld_r <= adv || (out_vld_r && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_dec_r  <= dec;
      out_acct_r <= acct_nxt;
    end
  end

  assign out_valid           = out_vld_r;
  assign out_granted         = out_dec_r.granted;
  assign out_verdict         = out_dec_r.verdict;
  assign out_used_now        = out_acct_r.used;
  assign out_peak_now        = out_acct_r.peak;
  assign out_throttled_total = out_acct_r.throttled;
  assign out_offence_count   = out_acct_r.offences;
  assign out_is_killed       = out_acct_r.killed;

  // Once set, the kill latch never clears short of reset.
  a_kill_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    acct_r.killed |=> acct_r.killed)
    else $error("kill latch cleared");

  // A held item is never dropped while the result side stalls.
  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (stg_vld_r && !adv) |=> (stg_vld_r && $stable(stg_units_r)))
    else $error("held item lost");

  // A grant never comes with a verdict or from a killed block.
  a_grant_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_granted) |-> (out_verdict == VERDICT_OK && !out_is_killed))
    else $error("grant with verdict or while killed");

  // The peak never falls below the usage reported with it.
  a_peak_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_peak_now >= out_used_now))
    else $error("peak below used");

endmodule

// ----- hdl/wql_step.sv -----
// Accounting step: next state and decision for one item from the current state.
module wql_step (
  input  wql_pkg::acct_t             acct,
  input  logic [wql_pkg::UNIT_W-1:0] ceiling,
  input  logic [wql_pkg::UNIT_W-1:0] strike_limit,
  input  wql_pkg::req_t              req_type,
  input  logic [wql_pkg::UNIT_W-1:0] units,
  output wql_pkg::acct_t             acct_nxt,
  output wql_pkg::decision_t         dec
);
  import wql_pkg::*;

  logic [UNIT_W:0]   sum;
  logic              over;
  logic [UNIT_W-1:0] used_sum;
  logic [UNIT_W-1:0] limit;
  logic [UNIT_W-1:0] streak_inc;
  logic [UNIT_W-1:0] offences_inc;

  // The ceiling test is one bit wider than the operands so that it cannot wrap.
  assign sum          = {1'b0, acct.used} + {1'b0, units};
  assign over         = (ceiling != '0) && (sum > {1'b0, ceiling});
  assign used_sum     = sum[UNIT_W] ? MAX_UNITS : sum[UNIT_W-1:0];
  assign limit        = (strike_limit == '0) ? ONE_UNIT : strike_limit;
  assign streak_inc   = (acct.streak == MAX_UNITS) ? acct.streak : acct.streak + ONE_UNIT;
  assign offences_inc = (acct.offences == MAX_UNITS) ? acct.offences
                                                     : acct.offences + ONE_UNIT;

  always_comb begin
    acct_nxt    = acct;
    dec.granted = 1'b0;
    dec.verdict = VERDICT_OK;
    unique case (req_type)
      REQ_CHARGE: begin
        priority if (acct.killed) begin
          acct_nxt.hit = 1'b1;
        end else if (over) begin
          acct_nxt.throttled = acct.throttled + {{(TOTAL_W-UNIT_W){1'b0}}, units};
          acct_nxt.hit       = 1'b1;
        end else begin
          acct_nxt.used = used_sum;
          if (used_sum > acct.peak) begin
            acct_nxt.peak = used_sum;
          end
          dec.granted = 1'b1;
        end
      end
      REQ_CLOSE: begin
        priority if (acct.killed) begin
          dec.verdict = VERDICT_KILL;
        end else if (!acct.hit) begin
          acct_nxt.streak = '0;
        end else begin
          acct_nxt.offences = offences_inc;
          acct_nxt.streak   = streak_inc;
          if (streak_inc >= limit) begin
            acct_nxt.killed = 1'b1;
            dec.verdict     = VERDICT_KILL;
          end else begin
            dec.verdict = VERDICT_THROTTLE;
          end
        end
        acct_nxt.used = '0;
        acct_nxt.hit  = 1'b0;
      end
      default: ;
    endcase
  end

endmodule
